// ===== design/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// srr_pkg
// Shared constants, command type and window helper for the selective-repeat
// receiver.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int WINDOW_MAX  = 16;
	localparam int SEQ_DEPTH   = 48;
	localparam int CHUNK_BYTES = 8;

	localparam int PSEQ_W    = 6;
	localparam int CHUNK_W   = 64;
	localparam int WS_W      = 5;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam int WIN_LIM_RAW = (WINDOW_MAX < SEQ_DEPTH / 3) ? WINDOW_MAX : SEQ_DEPTH / 3;
	localparam int WIN_LIM     = (WIN_LIM_RAW < 1) ? 1 : WIN_LIM_RAW;
	localparam int WIN_W       = (WIN_LIM > 1) ? $clog2(WIN_LIM) : 1;
	localparam int SEQ_W       = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
	localparam int CW          = ($clog2(SEQ_DEPTH + 1) > PSEQ_W) ? $clog2(SEQ_DEPTH + 1) : PSEQ_W;

	localparam int CMDQ_DEPTH = 2;
	localparam int CQ_PTR_W   = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = 2'd1;

	localparam logic KIND_ACK   = 1'b0;
	localparam logic KIND_CHUNK = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [PSEQ_W-1:0] ack;
		logic [SEQ_W-1:0]  addr;
		logic              last;
		logic              done;
	} cmd_t;

	function automatic logic [CW-1:0] eff_window(input logic [WS_W-1:0] ws);
		logic [CW-1:0] w;
		w = CW'(ws);
		if (w == '0) begin
			w = CW'(1);
		end else if (w > CW'(WIN_LIM)) begin
			w = CW'(WIN_LIM);
		end
		return w;
	endfunction

endpackage

// ===== design/srr_ram.sv =====
// ----------------------------------------------------------------------------
// srr_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module srr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 48
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/srr_front.sv =====
// ----------------------------------------------------------------------------
// srr_front
// Packet classifier and window state: acknowledges, buffers chunks and walks
// the in-order run at the window base, issuing result commands.
// ----------------------------------------------------------------------------
module srr_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [srr_pkg::PSEQ_W-1:0]       packet_seq,
	input  logic [srr_pkg::CHUNK_W-1:0]      packet_payload,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [srr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [srr_pkg::CFG_W-1:0]        cfg_data,
	output logic                             cmd_push,
	output srr_pkg::cmd_t                    cmd_data,
	input  logic                             cmd_full,
	output logic                             ram_we,
	output logic [srr_pkg::SEQ_W-1:0]        ram_waddr,
	output logic [srr_pkg::CHUNK_W-1:0]      ram_wdata
);
	import srr_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                 state_q;
	logic [WS_W-1:0]      win_size_q;
	logic [CFG_W-1:0]     total_q;
	logic [CFG_W-1:0]     bytes_q;
	logic [SEQ_W-1:0]     base_q;
	logic [SEQ_DEPTH-1:0] filled_q;
	logic                 fin_q;
	logic                 done_q;
	logic [WIN_W-1:0]     cnt_q;

	logic [CW-1:0]    win;
	logic [CW-1:0]    span;
	logic [CW-1:0]    seq_c;
	logic [CW-1:0]    base_c;
	logic [CW-1:0]    seq_off;
	logic [SEQ_W-1:0] seq_i;
	logic [SEQ_W-1:0] base_next;
	logic [CFG_W-1:0] bytes_next;
	logic             in_space;
	logic             in_win;
	logic             in_prev;
	logic             at_base;
	logic             live;
	logic             do_fill;
	logic             fin_next;
	logic             drain_go;
	logic             drain_last;
	logic             restart;

	assign win     = eff_window(win_size_q);
	assign span    = win + win + win;
	assign seq_c   = CW'(packet_seq);
	assign base_c  = CW'(base_q);
	assign seq_i   = SEQ_W'(packet_seq);
	assign seq_off = (seq_c >= base_c) ? seq_c - base_c : span - (base_c - seq_c);

	assign in_space = (seq_c < span) && (base_c < span);
	assign in_win   = in_space && (seq_off < win);
	assign at_base  = in_space && (seq_off == '0);
	assign in_prev  = in_space && (seq_off >= span - win);

	assign full    = (state_q != ST_IDLE) || cmd_full;
	assign live    = push && !full && !fin_q;
	assign do_fill = live && in_win && !filled_q[seq_i];

	assign bytes_next = !do_fill ? bytes_q :
		(bytes_q > CFG_W'(CHUNK_BYTES)) ? bytes_q - CFG_W'(CHUNK_BYTES) : '0;
	assign fin_next = (bytes_next == '0);

	assign base_next  = (base_c + CW'(1) == span) ? '0 : base_q + SEQ_W'(1);
	assign drain_last = (CW'(cnt_q) + CW'(1) == win) || !filled_q[base_next];
	assign drain_go   = (state_q == ST_DRAIN) && !cmd_full;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid &&
		(cfg_index == REG_WINDOW_SIZE || cfg_index == REG_TOTAL_BYTES);

	assign ram_we    = do_fill;
	assign ram_waddr = seq_i;
	assign ram_wdata = packet_payload;

	always_comb begin
		cmd_push = 1'b0;
		cmd_data = '0;
		if (drain_go) begin
			cmd_push      = 1'b1;
			cmd_data.kind = KIND_CHUNK;
			cmd_data.addr = base_q;
			cmd_data.last = drain_last;
			cmd_data.done = done_q;
		end else if (live && (in_win || in_prev)) begin
			cmd_push      = 1'b1;
			cmd_data.kind = KIND_ACK;
			cmd_data.ack  = packet_seq;
			cmd_data.last = !at_base;
			cmd_data.done = fin_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			win_size_q <= WS_W'(1);
			total_q    <= '0;
			bytes_q    <= '0;
			base_q     <= '0;
			filled_q   <= '0;
			fin_q      <= 1'b0;
			done_q     <= 1'b0;
			cnt_q      <= '0;
		end else if (restart) begin
			if (cfg_index == REG_WINDOW_SIZE) begin
				win_size_q <= cfg_data[WS_W-1:0];
			end
			if (cfg_index == REG_TOTAL_BYTES) begin
				total_q <= cfg_data;
				bytes_q <= cfg_data;
			end else begin
				bytes_q <= total_q;
			end
			state_q  <= ST_IDLE;
			base_q   <= '0;
			filled_q <= '0;
			fin_q    <= 1'b0;
		end else begin
			if (live) begin
				bytes_q <= bytes_next;
				fin_q   <= fin_next;
				if (do_fill) begin
					filled_q[seq_i] <= 1'b1;
				end
				if (at_base) begin
					state_q <= ST_DRAIN;
					cnt_q   <= '0;
					done_q  <= fin_next;
				end
			end
			if (drain_go) begin
				filled_q[base_q] <= 1'b0;
				base_q           <= base_next;
				cnt_q            <= cnt_q + WIN_W'(1);
				if (drain_last) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

endmodule

// ===== design/srr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// srr_cmd_fifo
// Short command queue between the classifier and the result stage.
// ----------------------------------------------------------------------------
module srr_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  srr_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output srr_pkg::cmd_t dout,
	output logic          empty
);
	import srr_pkg::*;

	cmd_t                mem_q [CMDQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CQ_CNT_W'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + CQ_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + CQ_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CQ_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CQ_CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/srr_back.sv =====
// ----------------------------------------------------------------------------
// srr_back
// Result stage: takes commands, reads buffered chunks and holds the result
// until it is popped.
// ----------------------------------------------------------------------------
module srr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_empty,
	input  srr_pkg::cmd_t               cmd_data,
	output logic                        cmd_pop,
	output logic                        ram_re,
	output logic [srr_pkg::SEQ_W-1:0]   ram_raddr,
	input  logic [srr_pkg::CHUNK_W-1:0] ram_rdata,
	output logic                        empty,
	input  logic                        pop,
	output logic                        kind,
	output logic [srr_pkg::PSEQ_W-1:0]  ack_number,
	output logic [srr_pkg::CHUNK_W-1:0] delivered_chunk,
	output logic                        last_of_run,
	output logic                        transfer_done
);
	import srr_pkg::*;

	logic              out_valid_q;
	logic              kind_q;
	logic [PSEQ_W-1:0] ack_q;
	logic              last_q;
	logic              done_q;
	logic              load;

	assign load      = !cmd_empty && (!out_valid_q || pop);
	assign cmd_pop   = load;
	assign ram_re    = load;
	assign ram_raddr = cmd_data.addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= cmd_data.kind;
			ack_q  <= cmd_data.ack;
			last_q <= cmd_data.last;
			done_q <= cmd_data.done;
		end
	end

	assign empty           = !out_valid_q;
	assign kind            = kind_q;
	assign ack_number      = ack_q;
	assign delivered_chunk = (kind_q == KIND_CHUNK) ? ram_rdata : '0;
	assign last_of_run     = last_q;
	assign transfer_done   = done_q;

endmodule

// ===== design/selective_repeat_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit
// Selective-repeat ARQ receiver: acknowledges packets, buffers out-of-order
// chunks and delivers the in-order run at the window base.
// a packet's first result is written to the command queue, then loaded into the result register, where it can be popped
// throughput: 1 packet per cycle while full is low; full holds packets off while chunks are released at the base
// the run walk at the window base sets the rate, one chunk per cycle while the command queue is not full
// reset: window 1, length 0, base 0, all slots empty, results queue empty
// ----------------------------------------------------------------------------
module selective_repeat_receiver_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [srr_pkg::PSEQ_W-1:0]    packet_seq,
	input  logic [srr_pkg::CHUNK_W-1:0]   packet_payload,
	output logic                          empty,
	input  logic                          pop,
	output logic                          kind,
	output logic [srr_pkg::PSEQ_W-1:0]    ack_number,
	output logic [srr_pkg::CHUNK_W-1:0]   delivered_chunk,
	output logic                          last_of_run,
	output logic                          transfer_done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srr_pkg::CFG_W-1:0]     cfg_data
);
	import srr_pkg::*;

	logic               fq_push;
	cmd_t               fq_din;
	logic               fq_full;
	logic               fq_pop;
	cmd_t               fq_dout;
	logic               fq_empty;
	logic               ram_we;
	logic [SEQ_W-1:0]   ram_waddr;
	logic [CHUNK_W-1:0] ram_wdata;
	logic               ram_re;
	logic [SEQ_W-1:0]   ram_raddr;
	logic [CHUNK_W-1:0] ram_rdata;

	srr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.packet_seq     (packet_seq),
		.packet_payload (packet_payload),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd_push       (fq_push),
		.cmd_data       (fq_din),
		.cmd_full       (fq_full),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata)
	);

	srr_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_din),
		.full   (fq_full),
		.pop    (fq_pop),
		.dout   (fq_dout),
		.empty  (fq_empty)
	);

	srr_ram #(
		.WIDTH (CHUNK_W),
		.DEPTH (SEQ_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_empty       (fq_empty),
		.cmd_data        (fq_dout),
		.cmd_pop         (fq_pop),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.empty           (empty),
		.pop             (pop),
		.kind            (kind),
		.ack_number      (ack_number),
		.delivered_chunk (delivered_chunk),
		.last_of_run     (last_of_run),
		.transfer_done   (transfer_done)
	);

endmodule

// ===== design/srr_checker.sv =====
// ----------------------------------------------------------------------------
// srr_checker
// Port-level checks on the result side of the selective-repeat receiver.
// ----------------------------------------------------------------------------
module srr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [5:0]  ack_number,
	input logic [63:0] delivered_chunk,
	input logic        last_of_run,
	input logic        transfer_done
);

	// a waiting result stays until popped
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(kind) && $stable(ack_number) &&
			$stable(delivered_chunk) && $stable(last_of_run) && $stable(transfer_done))
		else $error("result changed while waiting");

	// a run continues only with delivered chunks
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_run |=> empty || kind)
		else $error("run continued with an acknowledgement");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !last_of_run && transfer_done |=> empty || transfer_done)
		else $error("done flag dropped within a run");

endmodule

bind selective_repeat_receiver_unit srr_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.kind            (kind),
	.ack_number      (ack_number),
	.delivered_chunk (delivered_chunk),
	.last_of_run     (last_of_run),
	.transfer_done   (transfer_done)
);

// ===== test/selective_repeat_receiver_unit_test.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_unit_test
// Self-checking bench for the selective-repeat receiver. A scoreboard keeps
// its own copy of the window, slot and byte-count state. It predicts the
// acknowledgements and in-order deliveries of every accepted packet and checks
// each popped result against them in order. Directed packets cover the window
// edges, the previous-window band, the middle band, sequence numbers beyond
// the space, duplicates, zero length and finish. Random window sweeps follow
// under several window and length settings, with idle and stall mixes, a long
// receiver hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import srr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int DRAIN_CYCLES   = 64;
	localparam int RANDOM_PACKETS = 480;
	localparam int PHASE_PACKETS  = 60;

	typedef struct {
		logic               kind;
		logic [PSEQ_W-1:0]  ack;
		logic [CHUNK_W-1:0] chunk;
		logic               last;
		logic               done;
	} srr_result_t;

	class arq_scoreboard;
		srr_result_t        expected_q[$];
		logic [WS_W-1:0]    window_reg;
		logic [CFG_W-1:0]   length_reg;
		int                 base;
		bit                 filled[SEQ_DEPTH];
		logic [CHUNK_W-1:0] stored[SEQ_DEPTH];
		logic [CFG_W-1:0]   remaining;
		bit                 finished;
		int                 errors;

		function new();
			window_reg = WS_W'(1);
			length_reg = '0;
			errors = 0;
			restart();
		endfunction

		function void restart();
			base = 0;
			foreach (filled[i]) filled[i] = 1'b0;
			remaining = length_reg;
			finished = 1'b0;
		endfunction

		function int window();
			int w;
			int lim;
			lim = (WINDOW_MAX < SEQ_DEPTH / 3) ? WINDOW_MAX : SEQ_DEPTH / 3;
			if (lim < 1) lim = 1;
			w = int'(window_reg);
			if (w < 1) begin
				w = 1;
			end else if (w > lim) begin
				w = lim;
			end
			return w;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_WINDOW_SIZE: begin
					window_reg = data[WS_W-1:0];
					restart();
				end
				REG_TOTAL_BYTES: begin
					length_reg = data;
					restart();
				end
				default: ;
			endcase
		endfunction

		function void add(logic kind, int ack, logic [CHUNK_W-1:0] chunk);
			srr_result_t r;
			r.kind = kind;
			r.ack = PSEQ_W'(ack);
			r.chunk = chunk;
			r.last = 1'b0;
			r.done = 1'b0;
			expected_q.push_back(r);
		endfunction

		function void fill(int seq, logic [CHUNK_W-1:0] payload);
			if (!filled[seq]) begin
				filled[seq] = 1'b1;
				stored[seq] = payload;
				remaining = (remaining > CFG_W'(CHUNK_BYTES)) ? remaining - CFG_W'(CHUNK_BYTES) : '0;
			end
		endfunction

		function bit note_packet(logic [PSEQ_W-1:0] seq_in, logic [CHUNK_W-1:0] payload);
			int w;
			int s;
			int seq;
			int d;
			int first;
			int i;
			if (finished) return 1'b0;
			w = window();
			s = 3 * w;
			seq = int'(seq_in);
			first = expected_q.size();
			if (seq < s && base < s) begin
				d = (seq + s - base) % s;
				if (d == 0) begin
					add(KIND_ACK, seq, '0);
					fill(seq, payload);
					for (i = 0; i < w && filled[base]; i++) begin
						add(KIND_CHUNK, 0, stored[base]);
						filled[base] = 1'b0;
						base = (base + 1) % s;
					end
				end else if (d < w) begin
					add(KIND_ACK, seq, '0);
					fill(seq, payload);
				end else if (d >= s - w) begin
					add(KIND_ACK, seq, '0);
				end
			end
			if (remaining == '0) finished = 1'b1;
			for (i = first; i < expected_q.size(); i++) expected_q[i].done = finished;
			if (expected_q.size() > first) expected_q[expected_q.size() - 1].last = 1'b1;
			return 1'b1;
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_result(srr_result_t got);
			srr_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t ns: unexpected result, expected none actual kind %0h ack %0h chunk %0h",
					$time, got.kind, got.ack, got.chunk);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare("kind", 64'(want.kind), 64'(got.kind));
			compare("ack_number", 64'(want.ack), 64'(got.ack));
			compare("delivered_chunk", want.chunk, got.chunk);
			compare("last_of_run", 64'(want.last), 64'(got.last));
			compare("transfer_done", 64'(want.done), 64'(got.done));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic [PSEQ_W-1:0]    packet_seq = '0;
	logic [CHUNK_W-1:0]   packet_payload = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic                 kind;
	logic [PSEQ_W-1:0]    ack_number;
	logic [CHUNK_W-1:0]   delivered_chunk;
	logic                 last_of_run;
	logic                 transfer_done;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	arq_scoreboard sb;
	srr_result_t   popped;
	int            idle_pct = 0;
	int            stall_pct = 0;
	int            hold_left = 0;
	int            packets_counted = 0;

	selective_repeat_receiver_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.packet_seq(packet_seq),
		.packet_payload(packet_payload),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.ack_number(ack_number),
		.delivered_chunk(delivered_chunk),
		.last_of_run(last_of_run),
		.transfer_done(transfer_done),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				popped.kind = kind;
				popped.ack = ack_number;
				popped.chunk = delivered_chunk;
				popped.last = last_of_run;
				popped.done = transfer_done;
				sb.check_result(popped);
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	function automatic logic [CHUNK_W-1:0] random_chunk();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic wait_drained();
		while (sb.pending() > 0) @(posedge clk);
	endtask

	task automatic send(logic [PSEQ_W-1:0] seq, logic [CHUNK_W-1:0] payload);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		packet_seq <= seq;
		packet_payload <= payload;
		do @(posedge clk); while (full);
		if (sb.note_packet(seq, payload)) packets_counted++;
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
	endtask

	task automatic configure(int ws, logic [CFG_W-1:0] length, bit spare);
		push <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (spare) write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
		write_cfg(REG_WINDOW_SIZE, ($urandom & ~32'h1f) | CFG_W'(ws));
		write_cfg(REG_TOTAL_BYTES, length);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_burst();
		int w;
		int s;
		int b;
		int choice;
		int d;
		int i;
		int j;
		int t;
		int offsets[$];
		bit skip_some;
		w = sb.window();
		s = 3 * w;
		b = sb.base;
		choice = $urandom_range(0, 99);
		if (choice < 55) begin
			// shuffled sweep over the current window, base slot often last
			skip_some = $urandom_range(0, 1);
			for (d = 1; d < w; d++) begin
				if (!skip_some || $urandom_range(0, 3) != 0) offsets.push_back(d);
			end
			repeat ($urandom_range(0, 2)) offsets.push_back($urandom_range(0, w - 1));
			for (i = offsets.size() - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = offsets[i];
				offsets[i] = offsets[j];
				offsets[j] = t;
			end
			if ($urandom_range(0, 1)) begin
				offsets.push_back(0);
			end else begin
				offsets.insert($urandom_range(0, offsets.size()), 0);
			end
			foreach (offsets[k]) begin
				if (!sb.finished) send(PSEQ_W'((b + offsets[k]) % s), random_chunk());
			end
		end else begin
			repeat ($urandom_range(1, 4)) begin
				if (!sb.finished) begin
					b = sb.base;
					if (choice >= 85) begin
						send(PSEQ_W'($urandom_range(0, 63)), random_chunk());
					end else begin
						t = $urandom_range(0, 99);
						if (t < 40) begin
							d = $urandom_range(0, w - 1);
						end else if (t < 55) begin
							d = 0;
						end else if (t < 75) begin
							d = $urandom_range(s - w, s - 1);
						end else if (t < 90) begin
							d = $urandom_range(w, s - w - 1);
						end else begin
							d = -1;
						end
						if (d < 0) begin
							send(PSEQ_W'($urandom_range(s, 63)), random_chunk());
						end else begin
							send(PSEQ_W'((b + d) % s), random_chunk());
						end
					end
				end
			end
		end
	endtask

	initial begin
		#4_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int p;
		int ws;
		int phase_start;
		bit paused;
		logic [CFG_W-1:0] length;

		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero length finishes on the first packet
		send(6'd0, '0);
		send(6'd1, '1);

		// window 0 acts as 1, three chunks
		configure(0, 32'd24, 1'b1);
		send(6'd2, random_chunk());
		send(6'd1, random_chunk());
		send(6'd5, random_chunk());
		send(6'd0, random_chunk());
		send(6'd0, random_chunk());
		send(6'd1, random_chunk());
		send(6'd2, random_chunk());

		// window clamped to the limit, maximum length
		configure(31, 32'hffff_ffff, 1'b0);
		send(6'd47, '1);
		send(6'd15, random_chunk());
		send(6'd16, random_chunk());
		send(6'd32, random_chunk());
		send(6'd63, random_chunk());
		send(6'd3, random_chunk());
		send(6'd3, random_chunk());
		send(6'd1, random_chunk());
		send(6'd2, random_chunk());
		send(6'd0, '0);

		packets_counted = 0;
		paused = 1'b0;
		for (p = 0; packets_counted < RANDOM_PACKETS; p++) begin
			case (p % 6)
				0: ws = 16;
				1: ws = 1;
				2: ws = 31;
				3: ws = $urandom_range(2, 15);
				4: ws = 0;
				default: ws = $urandom_range(0, 31);
			endcase
			if (p % 3 == 2) begin
				length = $urandom_range(1, 600);
			end else if (p % 5 == 4) begin
				length = '1;
			end else begin
				length = $urandom;
			end
			configure(ws, length, p % 2 == 1);
			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 56;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 56;
				end
				default: begin
					idle_pct = 35;
					stall_pct = 35;
				end
			endcase
			if (p == 0) hold_left = 400;
			phase_start = packets_counted;
			while (packets_counted - phase_start < PHASE_PACKETS && !sb.finished) begin
				send_burst();
				if (p == 2 && !paused && packets_counted - phase_start >= PHASE_PACKETS / 2) begin
					push <= 1'b0;
					wait_drained();
					@(posedge clk);
					paused = 1'b1;
				end
			end
			if (sb.finished) begin
				send(PSEQ_W'($urandom_range(0, 63)), random_chunk());
				send(PSEQ_W'(sb.base), random_chunk());
			end
		end

		push <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
